/* rtl/core/grid_raycast_column_engine_macros.svh */
// Assertion macros for the grid raycast column engine checker.
// No dependencies; included by the checker file.
`ifndef GRID_RAYCAST_COLUMN_ENGINE_MACROS_SVH
`define GRID_RAYCAST_COLUMN_ENGINE_MACROS_SVH

// same-cycle implication, masked during reset
`define GRCE_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grce check failed");

// next-cycle implication, masked during reset
`define GRCE_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grce check failed");

// same-cycle implication, also checked while in reset
`define GRCE_AST_RST(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("grce reset check failed");

`endif

/* rtl/core/grce_pkg.sv */
// Shared types and constants for the grid raycast column engine.
// No dependencies.
package grce_pkg;

	localparam int MAP_SIDE      = 64;
	localparam int MAP_W         = $clog2(MAP_SIDE);
	localparam int ADDR_W        = 2 * MAP_W;
	localparam int SCREEN_WIDTH  = 1024;
	localparam int SCREEN_HEIGHT = 512;
	localparam int TEX_SIZE      = 256;
	localparam int CAM_SCALE     = 131072 / SCREEN_WIDTH;
	localparam int HALF_W        = SCREEN_WIDTH / 2;
	localparam int HALF_H        = SCREEN_HEIGHT / 2;

	localparam int R_W      = 20;
	localparam int DIST_W   = 57;
	localparam int PERP_W   = 45;
	localparam int DIV_NW   = 33;
	localparam int DIV_DW   = 45;
	localparam int DIV_CW   = $clog2(DIV_NW);
	localparam int HGT_W    = 24;
	localparam int CNT_W    = 8;
	localparam int MAX_STEPS = 2 * MAP_SIDE + 2;

	localparam logic [DIST_W-1:0] DIST_INF  = DIST_W'(64'd1 << 48);
	localparam logic [PERP_W-1:0] PERP_MAX  = PERP_W'(64'd1 << 44);
	localparam logic [HGT_W-1:0]  HGT_MAX   = 24'hFFFFFF;
	localparam logic [23:0]       STEP_MAX  = 24'hFFFFFF;
	localparam logic [22:0]       START_MAX = 23'h7FFFFF;
	localparam logic [DIV_NW-1:0] NUM_RECIP = DIV_NW'(64'd1 << 32);
	localparam logic [DIV_NW-1:0] NUM_HGT   = DIV_NW'(64'(SCREEN_HEIGHT) * 64'd65536);
	localparam logic [DIV_NW-1:0] NUM_STEP  = DIV_NW'(64'(TEX_SIZE) * 64'd65536);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;
	localparam logic [1:0] KIND_OPEN = 2'd0;
	localparam logic [1:0] KIND_WALL = 2'd1;

	localparam int APB_AW = 4;
	localparam logic [1:0] REG_POS_X = 2'd0;
	localparam logic [1:0] REG_POS_Y = 2'd1;
	localparam logic [1:0] REG_DIR_X = 2'd2;
	localparam logic [1:0] REG_DIR_Y = 2'd3;

	typedef struct packed {
		logic       opcode;
		logic [5:0] cell_x;
		logic [5:0] cell_y;
		logic [1:0] cell_kind;
		logic [9:0] column;
	} cmd_item_t;

	typedef struct packed {
		logic        wall_hit;
		logic [1:0]  texture_id;
		logic [7:0]  tex_column;
		logic [8:0]  draw_start;
		logic [8:0]  draw_end;
		logic [23:0] tex_step;
		logic [22:0] tex_start;
	} res_item_t;

	typedef enum logic [1:0] {
		DIV_DX,
		DIV_DY,
		DIV_HGT,
		DIV_STEP
	} div_sel_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DX_GO,
		ST_DX_WAIT,
		ST_DY_GO,
		ST_DY_WAIT,
		ST_SIDE_X,
		ST_SIDE_Y,
		ST_STEP,
		ST_CHECK,
		ST_PERP,
		ST_H_GO,
		ST_H_WAIT,
		ST_HGT,
		ST_S_GO,
		ST_S_WAIT,
		ST_TEX,
		ST_FIN,
		ST_VOID
	} state_t;

	typedef struct packed {
		logic     take;
		logic     clr;
		logic     div_go;
		logic     div_ld;
		div_sel_t div_sel;
		logic     side_x;
		logic     side_y;
		logic     step;
		logic     perp;
		logic     hgt;
		logic     tex;
		logic     ld_wall;
		logic     ld_void;
	} dp_cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic       cast_req;
		logic       div_done;
		logic       oog;
		logic [1:0] kind;
		logic       steps_done;
		logic       slot_free;
	} dp_sts_t;

endpackage

/* rtl/core/grce_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on grce_pkg.
module grce_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [grce_pkg::DIV_NW-1:0] num,
	input  logic [grce_pkg::DIV_DW-1:0] den,
	output logic                       done,
	output logic [grce_pkg::DIV_NW-1:0] quo
);
	import grce_pkg::*;

	logic              busy_q, done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW-1:0] rem_q, den_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CW'(DIV_NW - 1));
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIV_DW'(trial - {1'b0, den_q});
				quo_q <= {quo_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

/* rtl/core/grce_ctrl.sv */
// Sequencer for cell writes and column casts.
// Depends on grce_pkg; drives the datapath commands.
module grce_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  grce_pkg::dp_sts_t  sts,
	output grce_pkg::dp_cmd_t  dpc
);
	import grce_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLEAR:   if (sts.clr_done) state_n = ST_IDLE;
			ST_IDLE:    if (sts.cast_req) state_n = ST_DX_GO;
			ST_DX_GO:   state_n = ST_DX_WAIT;
			ST_DX_WAIT: if (sts.div_done) state_n = ST_DY_GO;
			ST_DY_GO:   state_n = ST_DY_WAIT;
			ST_DY_WAIT: if (sts.div_done) state_n = ST_SIDE_X;
			ST_SIDE_X:  state_n = ST_SIDE_Y;
			ST_SIDE_Y:  state_n = ST_STEP;
			ST_STEP:    state_n = ST_CHECK;
			ST_CHECK: begin
				if (sts.oog)
					state_n = ST_VOID;
				else if (sts.kind == KIND_WALL)
					state_n = ST_PERP;
				else if (sts.kind != KIND_OPEN || sts.steps_done)
					state_n = ST_VOID;
				else
					state_n = ST_STEP;
			end
			ST_PERP:    state_n = ST_H_GO;
			ST_H_GO:    state_n = ST_H_WAIT;
			ST_H_WAIT:  if (sts.div_done) state_n = ST_HGT;
			ST_HGT:     state_n = ST_S_GO;
			ST_S_GO:    state_n = ST_S_WAIT;
			ST_S_WAIT:  if (sts.div_done) state_n = ST_TEX;
			ST_TEX:     state_n = ST_FIN;
			ST_FIN:     if (sts.slot_free) state_n = ST_IDLE;
			ST_VOID:    if (sts.slot_free) state_n = ST_IDLE;
			default:    state_n = ST_CLEAR;
		endcase
	end

	always_comb begin
		dpc         = '0;
		dpc.div_sel = DIV_DX;
		case (state_q)
			ST_CLEAR:   dpc.clr = 1'b1;
			ST_IDLE:    dpc.take = 1'b1;
			ST_DX_GO:   dpc.div_go = 1'b1;
			ST_DX_WAIT: dpc.div_ld = 1'b1;
			ST_DY_GO: begin
				dpc.div_go  = 1'b1;
				dpc.div_sel = DIV_DY;
			end
			ST_DY_WAIT: begin
				dpc.div_ld  = 1'b1;
				dpc.div_sel = DIV_DY;
			end
			ST_SIDE_X:  dpc.side_x = 1'b1;
			ST_SIDE_Y:  dpc.side_y = 1'b1;
			ST_STEP:    dpc.step = 1'b1;
			ST_PERP:    dpc.perp = 1'b1;
			ST_H_GO: begin
				dpc.div_go  = 1'b1;
				dpc.div_sel = DIV_HGT;
			end
			ST_HGT:     dpc.hgt = 1'b1;
			ST_S_GO: begin
				dpc.div_go  = 1'b1;
				dpc.div_sel = DIV_STEP;
			end
			ST_TEX:     dpc.tex = 1'b1;
			ST_FIN:     dpc.ld_wall = sts.slot_free;
			ST_VOID:    dpc.ld_void = sts.slot_free;
			default:    dpc.div_sel = DIV_DX;
		endcase
	end
endmodule

/* rtl/core/grce_dp.sv */
// Datapath: map memory, ray setup, DDA walk, distance and texture math,
// result register. Depends on grce_pkg and grce_div.
module grce_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  grce_pkg::dp_cmd_t     dpc,
	output grce_pkg::dp_sts_t     sts,
	input  logic                  cmd_valid,
	input  grce_pkg::cmd_item_t   cmd,
	input  logic [21:0]           pos_x,
	input  logic [21:0]           pos_y,
	input  logic signed [17:0]    dir_x,
	input  logic signed [17:0]    dir_y,
	input  logic                  res_stall,
	output logic                  res_valid,
	output grce_pkg::res_item_t   res
);
	import grce_pkg::*;

	// map store and clearing sweep
	logic [1:0]      map_mem [0:MAP_SIDE*MAP_SIDE-1];
	logic [ADDR_W:0] clr_q;
	logic            clr_done, wr_item, mem_we;
	logic [ADDR_W-1:0] wa, ra;
	logic [1:0]      wd, kind_q;

	assign clr_done = clr_q[ADDR_W];
	assign wr_item  = dpc.take && cmd_valid && (cmd.opcode == OP_WRITE);
	assign mem_we   = (dpc.clr && !clr_done) || wr_item;
	assign wa       = dpc.clr ? clr_q[ADDR_W-1:0] : {cmd.cell_x, cmd.cell_y};
	assign wd       = dpc.clr ? KIND_OPEN : cmd.cell_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (dpc.clr && !clr_done)
			clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			map_mem[wa] <= wd;
		kind_q <= map_mem[ra];
	end

	// ray setup
	logic              cast_req;
	logic signed [17:0] col_off, cam;
	logic signed [35:0] pdy, pdx;
	logic signed [36:0] pdy_n;
	logic signed [R_W-1:0] rx_c, ry_c, rx_q, ry_q;
	logic [R_W-1:0]    arx, ary;
	logic              rx_neg, ry_neg, rx_zero, ry_zero;

	assign cast_req = cmd_valid && (cmd.opcode == OP_CAST) &&
		({1'b0, cmd.column} < 11'(SCREEN_WIDTH));
	assign col_off = signed'(18'(cmd.column)) - 18'(HALF_W);
	assign cam     = 18'(col_off * 18'(CAM_SCALE));
	assign pdy     = dir_y * cam;
	assign pdx     = dir_x * cam;
	assign pdy_n   = -(37'(pdy));
	assign rx_c    = R_W'(dir_x) + R_W'(pdy_n >>> 16);
	assign ry_c    = R_W'(dir_y) + R_W'(pdx >>> 16);

	assign rx_neg  = rx_q[R_W-1];
	assign ry_neg  = ry_q[R_W-1];
	assign rx_zero = (rx_q == '0);
	assign ry_zero = (ry_q == '0);
	assign arx     = rx_neg ? R_W'(-rx_q) : R_W'(rx_q);
	assign ary     = ry_neg ? R_W'(-ry_q) : R_W'(ry_q);

	// divider
	logic [DIV_NW-1:0] div_num, quo;
	logic [DIV_DW-1:0] div_den;
	logic              div_done;
	logic [PERP_W-1:0] perp_q;
	logic [HGT_W-1:0]  hgt_q;

	always_comb begin
		case (dpc.div_sel)
			DIV_DX: begin
				div_num = NUM_RECIP;
				div_den = DIV_DW'(arx);
			end
			DIV_DY: begin
				div_num = NUM_RECIP;
				div_den = DIV_DW'(ary);
			end
			DIV_HGT: begin
				div_num = NUM_HGT;
				div_den = perp_q;
			end
			default: begin
				div_num = NUM_STEP;
				div_den = DIV_DW'(hgt_q);
			end
		endcase
	end

	grce_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (dpc.div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	// DDA walk
	logic [DIST_W-1:0] dx_q, dy_q, sx_q, sy_q;
	logic [16:0]       fx, fy;
	logic [49:0]       fprod_x, fprod_y;
	logic [MAP_W:0]    mx_q, my_q, mx_n, my_n;
	logic              x_go, side_q, oog_q;
	logic [CNT_W-1:0]  cnt_q;

	assign fx      = rx_neg ? {1'b0, pos_x[15:0]} : 17'h10000 - {1'b0, pos_x[15:0]};
	assign fy      = ry_neg ? {1'b0, pos_y[15:0]} : 17'h10000 - {1'b0, pos_y[15:0]};
	assign fprod_x = fx * dx_q[32:0];
	assign fprod_y = fy * dy_q[32:0];
	assign x_go    = sx_q < sy_q;
	assign mx_n    = x_go ? (rx_neg ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
	assign my_n    = x_go ? my_q : (ry_neg ? my_q - 1'b1 : my_q + 1'b1);
	assign ra      = {mx_n[MAP_W-1:0], my_n[MAP_W-1:0]};

	always_ff @(posedge clk) begin
		if (dpc.take && cast_req) begin
			rx_q  <= rx_c;
			ry_q  <= ry_c;
			mx_q  <= {1'b0, pos_x[21:16]};
			my_q  <= {1'b0, pos_y[21:16]};
			cnt_q <= '0;
		end
		if (dpc.div_ld && div_done) begin
			if (dpc.div_sel == DIV_DX)
				dx_q <= rx_zero ? DIST_INF : DIST_W'(quo);
			else
				dy_q <= ry_zero ? DIST_INF : DIST_W'(quo);
		end
		if (dpc.side_x)
			sx_q <= rx_zero ? DIST_INF : DIST_W'(fprod_x >> 16);
		if (dpc.side_y)
			sy_q <= ry_zero ? DIST_INF : DIST_W'(fprod_y >> 16);
		if (dpc.step) begin
			if (x_go)
				sx_q <= sx_q + dx_q;
			else
				sy_q <= sy_q + dy_q;
			mx_q   <= mx_n;
			my_q   <= my_n;
			side_q <= !x_go;
			oog_q  <= mx_n[MAP_W] || my_n[MAP_W];
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	// distance, span and texture math
	logic [DIST_W-1:0] dist_c;
	logic              perp_zero, h_zero;
	logic [HGT_W-1:0]  hgt_c;
	logic [HGT_W-2:0]  h2;
	logic [8:0]        ds_q, de_q;
	logic [22:0]       num_q;
	logic signed [R_W-1:0] r_o;
	logic [31:0]       hprod_q;
	logic [23:0]       step_q;
	logic [39:0]       tprod_q;
	logic [15:0]       hit_f;
	logic [7:0]        tcol, tcol_m;
	logic              mirror;
	logic [1:0]        tex_id;
	logic [22:0]       tstart;

	assign dist_c    = side_q ? sy_q - dy_q : sx_q - dx_q;
	assign perp_zero = (perp_q == '0);
	assign hgt_c     = perp_zero ? '0 : (quo > DIV_NW'(HGT_MAX) ? HGT_MAX : quo[HGT_W-1:0]);
	assign h2        = hgt_c[HGT_W-1:1];
	assign r_o       = side_q ? rx_q : ry_q;
	assign h_zero    = (hgt_q == '0);

	always_ff @(posedge clk) begin
		if (dpc.perp)
			perp_q <= (dist_c > DIST_W'(PERP_MAX)) ? PERP_MAX : PERP_W'(dist_c);
		if (dpc.hgt) begin
			hgt_q   <= hgt_c;
			ds_q    <= (h2 >= 23'(HALF_H)) ? 9'd0 : 9'(23'(HALF_H) - h2);
			de_q    <= (h2 >= 23'(HALF_H - 1)) ? 9'(SCREEN_HEIGHT - 1) : 9'(h2 + 23'(HALF_H));
			num_q   <= (h2 > 23'(HALF_H)) ? 23'(h2 - 23'(HALF_H)) : '0;
			hprod_q <= 32'(perp_q[31:0] * 32'(r_o));
		end
		if (dpc.tex) begin
			step_q  <= (h_zero || quo > DIV_NW'(STEP_MAX)) ? STEP_MAX : quo[23:0];
			tprod_q <= h_zero ? '0 : num_q * quo[16:0];
		end
	end

	assign hit_f  = (side_q ? pos_x[15:0] : pos_y[15:0]) + hprod_q[31:16];
	assign tcol   = 8'((32'(hit_f) * 32'(TEX_SIZE)) >> 16);
	assign mirror = side_q ? ry_neg : (!rx_neg && !rx_zero);
	assign tcol_m = mirror ? 8'(TEX_SIZE - 1) - tcol : tcol;
	assign tex_id = side_q ? (ry_neg ? 2'd3 : 2'd2) : (rx_neg ? 2'd1 : 2'd0);
	assign tstart = (tprod_q > 40'(START_MAX)) ? START_MAX : tprod_q[22:0];

	// result register
	logic      res_valid_q;
	res_item_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (dpc.ld_wall || dpc.ld_void)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (dpc.ld_void)
			res_q <= '0;
		else if (dpc.ld_wall) begin
			res_q.wall_hit   <= 1'b1;
			res_q.texture_id <= tex_id;
			res_q.tex_column <= tcol_m;
			res_q.draw_start <= ds_q;
			res_q.draw_end   <= de_q;
			res_q.tex_step   <= step_q;
			res_q.tex_start  <= tstart;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign sts.clr_done   = clr_done;
	assign sts.cast_req   = cast_req;
	assign sts.div_done   = div_done;
	assign sts.oog        = oog_q;
	assign sts.kind       = kind_q;
	assign sts.steps_done = (cnt_q == CNT_W'(MAX_STEPS));
	assign sts.slot_free  = !res_valid_q || !res_stall;
endmodule

/* rtl/core/grid_raycast_column_engine.sv */
// Grid raycast column engine top level: register port, controller, datapath.
// Depends on grce_pkg, grce_ctrl, grce_dp.
//
//   channel  dir  handshake              payload
//   cmd      in   cmd_valid / cmd_stall  cmd (cmd_item_t)
//   res      out  res_valid / res_stall  res (res_item_t)
//   apb      in   psel/penable/pready    paddr, pwdata, prdata
//
// After reset a clearing pass writes all 4096 map cells, one per cycle;
// cmd_stall stays high through the pass and until the controller reaches idle.
// A cell write is done in the idle state. A cast runs N DDA steps (at most 130),
// each a step and a check state, and four divisions on the shared one-bit-per-cycle
// divider; a void ends early, before the height and step divisions.
// A finished result waits in the output register; the next item is taken
// while it is stalled, and the next cast waits in its last cycle for the slot.
module grid_raycast_column_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  grce_pkg::cmd_item_t         cmd,
	output logic                        res_valid,
	input  logic                        res_stall,
	output grce_pkg::res_item_t         res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [grce_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import grce_pkg::*;

	logic [21:0]        pos_x_q, pos_y_q;
	logic signed [17:0] dir_x_q, dir_y_q;
	logic               cfg_we;
	dp_cmd_t            dpc;
	dp_sts_t            sts;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			dir_x_q <= 18'sh10000;
			dir_y_q <= '0;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_POS_X: pos_x_q <= pwdata[21:0];
				REG_POS_Y: pos_y_q <= pwdata[21:0];
				REG_DIR_X: dir_x_q <= pwdata[17:0];
				REG_DIR_Y: dir_y_q <= pwdata[17:0];
				default:   pos_x_q <= pos_x_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_POS_X: prdata = 32'(pos_x_q);
			REG_POS_Y: prdata = 32'(pos_y_q);
			REG_DIR_X: prdata = 32'(dir_x_q);
			REG_DIR_Y: prdata = 32'(dir_y_q);
			default:   prdata = '0;
		endcase
	end

	assign cmd_stall = !dpc.take;

	grce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.dpc    (dpc)
	);

	grce_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dpc       (dpc),
		.sts       (sts),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pos_x     (pos_x_q),
		.pos_y     (pos_y_q),
		.dir_x     (dir_x_q),
		.dir_y     (dir_y_q),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res)
	);
endmodule

/* rtl/core/grce_chk.sv */
// Port-level checker for the grid raycast column engine, bound to the top.
// Depends on grce_pkg and grid_raycast_column_engine_macros.svh.
`include "grid_raycast_column_engine_macros.svh"

module grce_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_stall,
	input grce_pkg::cmd_item_t cmd,
	input logic                res_valid,
	input logic                res_stall,
	input grce_pkg::res_item_t res
);
	import grce_pkg::*;

	`GRCE_AST_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
	`GRCE_AST_RST(a_rst_idle, !arst_n, !res_valid)
	`GRCE_AST_NXT(a_write_silent, cmd_valid && !cmd_stall && cmd.opcode == OP_WRITE && !res_valid, !res_valid)
	`GRCE_AST_IMP(a_void_zero, res_valid && !res.wall_hit, res.texture_id == 2'd0 && res.tex_column == 8'd0 && res.draw_start == 9'd0 && res.draw_end == 9'd0 && res.tex_step == 24'd0 && res.tex_start == 23'd0)
	`GRCE_AST_IMP(a_span_order, res_valid && res.wall_hit, res.draw_start <= res.draw_end)
endmodule

bind grid_raycast_column_engine grce_chk u_chk (.*);

/* tb/grid_raycast_column_engine_tb.sv */
// Self-checking testbench for grid_raycast_column_engine: DDA column casts and map writes.
// A predictor mirrors the map, the pose registers and the Q16 cast math.
// Results are checked in order. Depends on grce_pkg and the engine RTL.
`timescale 1ns / 100ps

module grid_raycast_column_engine_tb;
	import grce_pkg::*;

	localparam logic [1:0] KIND_BLOCK = 2'd2;
	localparam logic [1:0] KIND_ODD   = 2'd3;
	localparam int HOLD_CYCLES  = 3000;
	localparam int SETTLE       = 600;
	localparam longint LIMIT    = 6000000;
	localparam longint unsigned INF_DIST = 64'd1 << 48;
	localparam longint unsigned PERP_CAP = 64'd1 << 44;

	logic clk, arst_n;
	logic cmd_valid, cmd_stall, res_valid, res_stall;
	cmd_item_t cmd;
	res_item_t res;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [31:0] pwdata, prdata;

	grid_raycast_column_engine dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [1:0] grid [MAP_SIDE][MAP_SIDE] = '{default: KIND_OPEN};
	longint unsigned view_x, view_y;
	longint view_dx, view_dy;

	cmd_item_t pending_cmds[$];
	res_item_t column_q[$];
	int errors = 0;
	int reported = 0;
	bit burst;
	int send_gap, stall_left, hold_left;
	bit hold_req, hold_done;
	longint cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	function automatic longint fl16(input longint v);
		if (v >= 0) return v >>> 16;
		return -(((-v) + 65535) >>> 16);
	endfunction

	function automatic longint unsigned recip(input longint r);
		longint unsigned a;
		a = (r < 0) ? -r : r;
		if (a == 0) return INF_DIST;
		return (64'd1 << 32) / a;
	endfunction

	function automatic longint unsigned side_start(input longint unsigned p, input longint r,
			input longint unsigned d);
		longint unsigned f;
		f = p & 64'hFFFF;
		if (d == INF_DIST) return INF_DIST;
		if (r >= 0) f = 64'h10000 - f;
		return (f * d) >> 16;
	endfunction

	// returns 1 when the item produces a column descriptor
	function automatic bit cast_column(input cmd_item_t it, output res_item_t r);
		longint cam, rx, ry, mx, my, hitpt, ds, de, sxs, sys, num;
		longint unsigned dx, dy, sx, sy, perp, hgt, stp, tst, f, tcol, raw;
		int side, k;
		bit found, wall;
		logic [1:0] kind;
		r = '0;
		if (it.opcode == OP_WRITE) begin
			grid[it.cell_x][it.cell_y] = it.cell_kind;
			return 0;
		end
		if (int'(it.column) >= SCREEN_WIDTH) return 0;
		cam = ((2 * longint'(it.column) - SCREEN_WIDTH) * 65536) / SCREEN_WIDTH;
		rx = view_dx + fl16(-view_dy * cam);
		ry = view_dy + fl16(view_dx * cam);
		mx = longint'(view_x >> 16);
		my = longint'(view_y >> 16);
		if (mx >= MAP_SIDE || my >= MAP_SIDE) return 1;
		dx = recip(rx);
		dy = recip(ry);
		sx = side_start(view_x, rx, dx);
		sy = side_start(view_y, ry, dy);
		sxs = rx < 0 ? -1 : 1;
		sys = ry < 0 ? -1 : 1;
		side = 1;
		found = 0;
		wall = 0;
		for (k = 0; k < 2 * MAP_SIDE + 2 && !found; k++) begin
			if (sx < sy) begin
				sx += dx; mx += sxs; side = 0;
			end else begin
				sy += dy; my += sys; side = 1;
			end
			if (mx < 0 || my < 0 || mx >= MAP_SIDE || my >= MAP_SIDE) return 1;
			kind = grid[mx][my];
			if (kind != KIND_OPEN) begin
				found = 1;
				wall = (kind == KIND_WALL);
			end
		end
		if (!found || !wall) return 1;
		perp = (side == 0) ? sx - dx : sy - dy;
		if (perp > PERP_CAP) perp = PERP_CAP;
		hgt = 0;
		if (perp != 0) begin
			hgt = (64'(SCREEN_HEIGHT) * 65536) / perp;
			if (hgt > 64'hFFFFFF) hgt = 64'hFFFFFF;
		end
		ds = -longint'(hgt / 2) + SCREEN_HEIGHT / 2;
		if (ds < 0) ds = 0;
		de = longint'(hgt / 2) + SCREEN_HEIGHT / 2;
		if (de >= SCREEN_HEIGHT) de = SCREEN_HEIGHT - 1;
		if (side == 0) hitpt = longint'(view_y) + fl16(longint'(perp) * ry);
		else hitpt = longint'(view_x) + fl16(longint'(perp) * rx);
		f = hitpt & 64'hFFFF;
		tcol = (f * TEX_SIZE) >> 16;
		if ((side == 0 && rx > 0) || (side == 1 && ry < 0)) tcol = TEX_SIZE - tcol - 1;
		tst = 0;
		if (hgt == 0) begin
			stp = 64'hFFFFFF;
		end else begin
			raw = (64'(TEX_SIZE) * 65536) / hgt;
			num = ds - SCREEN_HEIGHT / 2 + longint'(hgt / 2);
			if (num > 0) tst = longint'(num) * raw;
			stp = raw > 64'hFFFFFF ? 64'hFFFFFF : raw;
		end
		if (tst > 64'h7FFFFF) tst = 64'h7FFFFF;
		r.wall_hit   = 1'b1;
		r.texture_id = side == 0 ? (sxs == 1 ? 2'd0 : 2'd1) : (sys == 1 ? 2'd2 : 2'd3);
		r.tex_column = tcol[7:0];
		r.draw_start = ds[8:0];
		r.draw_end   = de[8:0];
		r.tex_step   = stp[23:0];
		r.tex_start  = tst[22:0];
		return 1;
	endfunction

	// driver
	always @(posedge clk) begin
		res_item_t r;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			send_gap = 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				if (cast_column(cmd, r)) column_q.push_back(r);
			if (!cmd_valid || !cmd_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cmd <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
					send_gap = rand_gap();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// long hold-off of the result side
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
		end else if (hold_left > 0) begin
			res_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
			stall_left = rand_gap();
		end
	end

	// monitor
	always @(posedge clk) begin
		res_item_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (column_q.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected column result %p", res);
				end
			end else begin
				e = column_q.pop_front();
				if (res.wall_hit !== e.wall_hit || res.texture_id !== e.texture_id ||
						res.tex_column !== e.tex_column || res.draw_start !== e.draw_start ||
						res.draw_end !== e.draw_end || res.tex_step !== e.tex_step ||
						res.tex_start !== e.tex_start) begin
					errors++;
					if (reported < 10) begin
						reported++;
						$display("column mismatch: expected %p actual %p", e, res);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= APB_AW'(idx * 4); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_POS_X: view_x = val & 32'h3FFFFF;
			REG_POS_Y: view_y = val & 32'h3FFFFF;
			REG_DIR_X: view_dx = longint'($signed(val[17:0]));
			REG_DIR_Y: view_dy = longint'($signed(val[17:0]));
			default: ;
		endcase
	endtask

	task automatic set_pose(input logic [31:0] px, input logic [31:0] py,
			input longint ddx, input longint ddy);
		apb_write(REG_POS_X, px);
		apb_write(REG_POS_Y, py);
		apb_write(REG_DIR_X, 32'(ddx));
		apb_write(REG_DIR_Y, 32'(ddy));
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || cmd_valid || column_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic cmd_item_t mk_write(input int x, input int y, input logic [1:0] k);
		cmd_item_t c;
		c = '0;
		c.opcode = OP_WRITE;
		c.cell_x = 6'(x); c.cell_y = 6'(y); c.cell_kind = k;
		c.column = 10'($urandom);
		return c;
	endfunction

	function automatic cmd_item_t mk_cast(input int col);
		cmd_item_t c;
		c = '0;
		c.cell_x = 6'($urandom);
		c.cell_y = 6'($urandom);
		c.cell_kind = 2'($urandom);
		c.opcode = OP_CAST;
		c.column = 10'(col);
		return c;
	endfunction

	function automatic logic [31:0] rand_pos();
		logic [15:0] frac;
		frac = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
		return {10'd0, 6'($urandom_range(1, 62)), frac};
	endfunction

	function automatic longint rand_dir();
		case ($urandom_range(0, 5))
			0: return 65536;
			1: return -65536;
			2: return 0;
			default: return longint'($urandom_range(0, 131072)) - 65536;
		endcase
	endfunction

	initial begin
		int ph, i, n;
		logic [1:0] k;
		burst = 1'b0; hold_req = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		view_x = 0; view_y = 0; view_dx = 65536; view_dy = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty map void, straight ray, edges of the screen, all kinds
		pending_cmds.push_back(mk_cast(0));
		pending_cmds.push_back(mk_cast(512));
		pending_cmds.push_back(mk_cast(SCREEN_WIDTH - 1));
		pending_cmds.push_back(mk_write(5, 0, KIND_WALL));
		pending_cmds.push_back(mk_cast(512));
		pending_cmds.push_back(mk_cast(511));
		pending_cmds.push_back(mk_write(1, 0, KIND_WALL));
		pending_cmds.push_back(mk_cast(512));
		pending_cmds.push_back(mk_write(1, 0, KIND_BLOCK));
		pending_cmds.push_back(mk_cast(512));
		pending_cmds.push_back(mk_write(1, 0, KIND_ODD));
		pending_cmds.push_back(mk_cast(512));
		pending_cmds.push_back(mk_write(1, 0, KIND_OPEN));
		pending_cmds.push_back(mk_write(63, 63, KIND_WALL));
		pending_cmds.push_back(mk_cast(SCREEN_WIDTH - 1));
		drain();

		// zero distance: viewer on a grid line, wall just ahead in -x
		set_pose({10'd0, 6'd3, 16'd0}, {10'd0, 6'd3, 16'h8000}, -65536, 0);
		pending_cmds.push_back(mk_write(2, 3, KIND_WALL));
		pending_cmds.push_back(mk_cast(512));
		pending_cmds.push_back(mk_cast(0));
		pending_cmds.push_back(mk_cast(SCREEN_WIDTH - 1));
		drain();
		set_pose(32'h3FFFFF, 32'h3FFFFF, 65536, 65536);
		pending_cmds.push_back(mk_cast(512));
		drain();
		set_pose(32'd0, 32'd0, 0, -65536);
		pending_cmds.push_back(mk_cast(100));
		drain();

		// border ring of walls
		for (i = 0; i < MAP_SIDE; i++) begin
			pending_cmds.push_back(mk_write(i, 0, KIND_WALL));
			pending_cmds.push_back(mk_write(i, MAP_SIDE - 1, KIND_WALL));
			if (i > 0 && i < MAP_SIDE - 1) begin
				pending_cmds.push_back(mk_write(0, i, KIND_WALL));
				pending_cmds.push_back(mk_write(MAP_SIDE - 1, i, KIND_WALL));
			end
		end

		for (ph = 0; ph < 10; ph++) begin
			drain();
			case (ph)
				0: set_pose(rand_pos(), rand_pos(), 65536, 0);
				1: set_pose(rand_pos(), rand_pos(), 0, 65536);
				2: set_pose(rand_pos(), rand_pos(), -65536, 0);
				3: set_pose(rand_pos(), rand_pos(), 0, -65536);
				4: set_pose(rand_pos(), rand_pos(), 46341, -46341);
				default: set_pose(rand_pos(), rand_pos(), rand_dir(), rand_dir());
			endcase
			burst = ($urandom_range(0, 3) == 0);
			if (ph == 3) hold_req <= 1'b1;
			n = 108;
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 4) == 0) begin
					k = ($urandom_range(0, 1) == 0) ? KIND_WALL : 2'($urandom);
					pending_cmds.push_back(mk_write($urandom_range(0, 63),
						$urandom_range(0, 63), k));
				end else begin
					case ($urandom_range(0, 19))
						0: pending_cmds.push_back(mk_cast(0));
						1: pending_cmds.push_back(mk_cast(SCREEN_WIDTH - 1));
						2: pending_cmds.push_back(mk_cast(SCREEN_WIDTH / 2));
						default: pending_cmds.push_back(mk_cast($urandom_range(0, 1023)));
					endcase
				end
			end
		end
		drain();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/grce_pkg.sv
rtl/core/grce_div.sv
rtl/core/grce_ctrl.sv
rtl/core/grce_dp.sv
rtl/core/grid_raycast_column_engine.sv
rtl/core/grce_chk.sv
tb/grid_raycast_column_engine_tb.sv
